>>> hdl/sdu_pkg.sv
// Shared types and operation codes for the step-division unit.
package sdu_pkg;

    localparam int WordWidth = 32;
    localparam int OpWidth   = 3;
    localparam int SignBit   = 31;

    localparam logic [OpWidth-1:0] OP_LOAD   = 3'd0;
    localparam logic [OpWidth-1:0] OP_INIT_S = 3'd1;
    localparam logic [OpWidth-1:0] OP_INIT_U = 3'd2;
    localparam logic [OpWidth-1:0] OP_STEP   = 3'd3;
    localparam logic [OpWidth-1:0] OP_REMFIX = 3'd4;
    localparam logic [OpWidth-1:0] OP_QUOFIX = 3'd5;

    typedef logic [WordWidth-1:0] word_t;
    typedef logic [OpWidth-1:0]   op_t;

    // Accumulator and sign flags.
    typedef struct packed {
        word_t high_word;
        word_t low_word;
        logic  dividend_sign;
        logic  divisor_sign;
    } sdu_state_t;

    // One registered instruction.
    typedef struct packed {
        op_t   operation;
        word_t operand_value;
    } sdu_instr_t;

endpackage

>>> hdl/sdu_alu.sv
// Combinational next-state and trap logic for one step-division instruction.
module sdu_alu import sdu_pkg::*; (
    input  sdu_state_t cur_state,
    input  sdu_instr_t instr,
    output sdu_state_t next_state,
    output logic       trap
);

    word_t d;
    word_t sh_high;
    word_t sh_low;
    word_t step_t;
    logic  step_lt;
    logic  step_eq;
    logic  step_take;
    word_t fix_t;
    logic  signs_same;

    assign d          = instr.operand_value;
    assign signs_same = (cur_state.dividend_sign == cur_state.divisor_sign);

    // Step: shift accumulator left, then trial subtract or add.
    assign sh_high = {cur_state.high_word[WordWidth-2:0], cur_state.low_word[SignBit]};
    assign sh_low  = {cur_state.low_word[WordWidth-2:0], 1'b0};
    assign step_t  = signs_same ? (sh_high - d) : (sh_high + d);
    assign step_lt = (step_t < sh_high);
    assign step_eq = (step_t == sh_high);

    always_comb begin
        unique case ({cur_state.dividend_sign, cur_state.divisor_sign})
            2'b00:   step_take = step_lt || step_eq;
            2'b01:   step_take = step_lt;
            2'b10:   step_take = !step_lt;
            default: step_take = !step_lt && !step_eq;
        endcase
    end

    // Remainder fix trial value.
    assign fix_t = cur_state.divisor_sign ? (cur_state.high_word - d)
                                          : (cur_state.high_word + d);

    always_comb begin
        next_state = cur_state;
        trap       = 1'b0;
        unique case (instr.operation)
            OP_LOAD: begin
                next_state.low_word = d;
            end
            OP_INIT_S: begin
                if (d == '0) begin
                    trap = 1'b1;
                end else begin
                    next_state.dividend_sign = cur_state.low_word[SignBit];
                    next_state.divisor_sign  = d[SignBit];
                    next_state.high_word     = {WordWidth{cur_state.low_word[SignBit]}};
                end
            end
            OP_INIT_U: begin
                if (d == '0) begin
                    trap = 1'b1;
                end else begin
                    next_state.high_word     = '0;
                    next_state.dividend_sign = 1'b0;
                    next_state.divisor_sign  = 1'b0;
                end
            end
            OP_STEP: begin
                next_state.high_word = step_take ? step_t : sh_high;
                next_state.low_word  = {sh_low[WordWidth-1:1], step_take};
            end
            OP_REMFIX: begin
                if (cur_state.dividend_sign && (fix_t == '0)) begin
                    next_state.high_word = '0;
                    next_state.low_word  = cur_state.low_word + word_t'(1);
                end
            end
            OP_QUOFIX: begin
                if (!signs_same) begin
                    next_state.low_word = word_t'(0) - cur_state.low_word;
                end
            end
            default: begin
                // unused codes leave state untouched
            end
        endcase
    end

endmodule

>>> hdl/step_division_unit.sv
// Top level of the step-division unit: input register, accumulator state and result register.
// Path: an accepted transfer is captured in the input register; the ALU works on it and
//   loads the result register, which drives m_*, once that register is free.
// Throughput: one instruction per cycle unless the result register is held; the ALU pass (one
//   32-bit add/sub, compare) is combinational, so back-to-back instructions chain via state.
// Reset: aresetn is synchronous, active low; it clears the accumulator, both sign
//   flags and both valid flags. Payload registers are not reset.
module step_division_unit import sdu_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] operand_value
    input  logic [2:0]  s_tuser,   // [2:0] operation
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] quotient_word, [63:32] remainder_word
    output logic        m_tuser    // [0] zero_divide_trap
);

    // input register
    sdu_instr_t instr_reg;
    logic       in_valid_reg;

    // accumulator
    sdu_state_t state_reg;
    sdu_state_t state_next;
    logic       trap_next;

    // result register
    logic        out_valid_reg;
    logic [63:0] out_data_reg;
    logic        out_trap_reg;

    logic out_free;
    logic exec;   // instruction in input register moves through ALU this cycle
    logic s_xfer;

    assign out_free = !out_valid_reg || m_tready;
    assign exec     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_xfer   = s_tvalid && s_tready;

    sdu_alu u_alu (
        .cur_state  (state_reg),
        .instr      (instr_reg),
        .next_state (state_next),
        .trap       (trap_next)
    );

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            instr_reg.operation     <= s_tuser;
            instr_reg.operand_value <= s_tdata;
        end
    end

    // state update commits together with the result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (exec) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec) begin
            out_data_reg <= {state_next.high_word, state_next.low_word};
            out_trap_reg <= trap_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_trap_reg;

    // A trapped init leaves the accumulator and flags untouched.
    a_trap_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        exec && trap_next |=> $stable(state_reg))
        else $error("trap modified state");

    // Only an init with a zero divisor can trap.
    a_trap_source: assert property (@(posedge aclk) disable iff (!aresetn)
        exec && trap_next |-> ((instr_reg.operation == OP_INIT_S ||
                                instr_reg.operation == OP_INIT_U) &&
                               instr_reg.operand_value == '0))
        else $error("trap from wrong operation");

    // A successful unsigned init clears the high word and both sign flags.
    a_init_u_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        exec && instr_reg.operation == OP_INIT_U && !trap_next |=>
        state_reg.high_word == '0 && !state_reg.dividend_sign && !state_reg.divisor_sign)
        else $error("unsigned init did not clear");

    // Stall on input only when both stages are full and output is blocked.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("spurious input stall");

    // Result register reflects the committed state.
    a_result_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        exec |=> out_data_reg == {state_reg.high_word, state_reg.low_word})
        else $error("result differs from state");

endmodule

>>> sim/tb.sv
// Self-checking testbench for the step-division unit: a shadow accumulator predicts each result.
module tb import sdu_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    // Spare operation codes; the unit must treat them as no-ops.
    localparam op_t OP_SPARE_6 = 3'd6;
    localparam op_t OP_SPARE_7 = 3'd7;

    localparam int RandomInstrs = 950;  // random-phase instruction budget
    localparam int QuietTail    = 120;  // last instructions run with no idling
    localparam int HoldAtInstr  = 300;  // where the long receiver hold-off starts
    localparam int HoldCycles   = 100;  // length of that hold-off
    localparam int DrainCycles  = 8;    // settle time after the last result
    localparam int MaxReports   = 10;

    // Result words expected back for one instruction.
    typedef struct {
        word_t quotient;
        word_t remainder;
        logic  trap;
    } step_result_t;

    // Shadow accumulator plus in-order queue of predicted results.
    class division_tracker;
        word_t          acc_high;
        word_t          acc_low;
        bit             dividend_neg;
        bit             divisor_neg;
        step_result_t   expected_words[$];
        int             mismatches;
        int             traps_seen;

        function new();
            acc_high     = '0;
            acc_low      = '0;
            dividend_neg = 1'b0;
            divisor_neg  = 1'b0;
            mismatches   = 0;
            traps_seen   = 0;
        endfunction

        // Apply one accepted instruction to the shadow state and queue its result.
        function void note_instruction(op_t op, word_t operand);
            word_t        sum;
            bit           take;
            bit           trap_hit;
            step_result_t res;
            trap_hit = 1'b0;
            case (op)
                OP_LOAD: acc_low = operand;
                OP_INIT_S: begin
                    if (operand == '0) begin
                        trap_hit = 1'b1;
                    end else begin
                        dividend_neg = acc_low[SignBit];
                        divisor_neg  = operand[SignBit];
                        acc_high     = dividend_neg ? '1 : '0;
                    end
                end
                OP_INIT_U: begin
                    if (operand == '0) begin
                        trap_hit = 1'b1;
                    end else begin
                        acc_high     = '0;
                        dividend_neg = 1'b0;
                        divisor_neg  = 1'b0;
                    end
                end
                OP_STEP: begin
                    acc_high = {acc_high[WordWidth-2:0], acc_low[SignBit]};
                    acc_low  = {acc_low[WordWidth-2:0], 1'b0};
                    // same signs subtract, mixed signs add; carry test is unsigned
                    sum = (dividend_neg == divisor_neg) ? acc_high - operand
                                                        : acc_high + operand;
                    if (!dividend_neg)
                        take = divisor_neg ? (sum < acc_high) : (sum <= acc_high);
                    else
                        take = divisor_neg ? (sum > acc_high) : (sum >= acc_high);
                    if (take) begin
                        acc_high   = sum;
                        acc_low[0] = 1'b1;
                    end
                end
                OP_REMFIX: begin
                    // negative dividend: a remainder of exactly one divisor rolls over
                    if (dividend_neg) begin
                        sum = divisor_neg ? acc_high - operand : acc_high + operand;
                        if (sum == '0) begin
                            acc_high = '0;
                            acc_low  = acc_low + 1'b1;
                        end
                    end
                end
                OP_QUOFIX: begin
                    if (dividend_neg != divisor_neg)
                        acc_low = '0 - acc_low;
                end
                default: ;
            endcase
            res.quotient  = acc_low;
            res.remainder = acc_high;
            res.trap      = trap_hit;
            expected_words.push_back(res);
        endfunction

        // Compare one accepted result with the oldest prediction.
        function void check_result(word_t quo, word_t rem, logic trap);
            step_result_t want;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= MaxReports)
                    $display("%t: result with nothing pending: quo %h rem %h trap %b",
                             $realtime, quo, rem, trap);
                return;
            end
            want = expected_words.pop_front();
            if (trap === 1'b1)
                traps_seen++;
            if (want.quotient !== quo || want.remainder !== rem || want.trap !== trap) begin
                mismatches++;
                if (mismatches <= MaxReports)
                    $display("%t: expected quo %h rem %h trap %b, got quo %h rem %h trap %b",
                             $realtime, want.quotient, want.remainder, want.trap,
                             quo, rem, trap);
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // [31:0] operand_value
    logic [2:0]  s_tuser;    // [2:0] operation
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;    // [31:0] quotient_word, [63:32] remainder_word
    logic        m_tuser;    // [0] zero_divide_trap

    division_tracker tracker;

    bit idle_on;        // random idle bursts enabled on both channels
    bit hold_asked;     // main flow asks the receiver for its long hold-off
    int instrs_sent;    // accepted instructions with a real opcode
    int full_divs;
    int signed_divs;
    int odd_runs;       // broken divisions and noise bursts

    step_division_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 4 ns clock
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Monitor: both channels sampled at the rising edge. An input's result passes the input
    // register and then the result register before m_*, so noting before checking is safe.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                tracker.note_instruction(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                tracker.check_result(m_tdata[31:0], m_tdata[63:32], m_tuser);
        end
    end

    // Receiver: random stall bursts, plus one long hold-off counted here so the
    // unit backs up and drops s_tready while the sender keeps offering.
    initial begin
        int  stall_left;
        bit  hold_taken;
        stall_left = 0;
        hold_taken = 1'b0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_asked && !hold_taken) begin
                hold_taken = 1'b1;
                m_tready <= 1'b0;
                repeat (HoldCycles - 1) @(negedge aclk);
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(0, 6);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one instruction; entered and left at a falling edge. tvalid is left
    // high so back-to-back transfers need no second assignment in a step.
    task automatic send_instr(op_t op, word_t operand);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= operand;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (op <= OP_QUOFIX)
            instrs_sent++;
    endtask

    // Biased operand: edge values often, otherwise fully random.
    function automatic word_t pick_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return word_t'($urandom_range(1, 16));
            5: return '0 - word_t'($urandom_range(1, 16));
            default: return word_t'($urandom);
        endcase
    endfunction

    // Load, init, some steps, and optionally the two sign fix-ups.
    task automatic run_division(word_t dividend, word_t divisor, bit signed_div,
                                int steps, bit with_fix);
        send_instr(OP_LOAD, dividend);
        send_instr(signed_div ? OP_INIT_S : OP_INIT_U, divisor);
        repeat (steps) send_instr(OP_STEP, divisor);
        if (with_fix) begin
            send_instr(OP_REMFIX, divisor);
            send_instr(OP_QUOFIX, divisor);
        end
    endtask

    initial begin
        word_t dvd;
        word_t dvs;
        bit    sgn;
        int    pick;
        tracker     = new();
        idle_on     = 1'b0;
        hold_asked  = 1'b0;
        instrs_sent = 0;
        full_divs   = 0;
        signed_divs = 0;
        odd_runs    = 0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = OP_LOAD;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: traps, spare codes, both fix-ups taking and not taking, extremes.
        idle_on = 1'b1;
        send_instr(OP_STEP, '0);                 // step straight out of reset
        send_instr(OP_LOAD, '1);
        send_instr(OP_INIT_S, '0);               // zero divisor traps, state kept
        send_instr(OP_INIT_U, '0);
        send_instr(OP_INIT_S, 32'h8000_0000);    // both signs negative
        send_instr(OP_STEP, 32'h8000_0000);
        send_instr(OP_STEP, '1);
        send_instr(OP_SPARE_6, '1);
        send_instr(OP_SPARE_7, '0);
        send_instr(OP_LOAD, 32'h8000_0000);
        send_instr(OP_INIT_S, 32'h0000_0001);    // negative dividend, positive divisor
        send_instr(OP_REMFIX, 32'h0000_0001);    // remainder plus divisor is zero
        send_instr(OP_QUOFIX, '0);               // mixed signs negate quotient
        send_instr(OP_LOAD, '1);
        send_instr(OP_INIT_S, '1);
        send_instr(OP_REMFIX, '1);               // remainder minus divisor is zero
        send_instr(OP_REMFIX, 32'h0000_0005);    // nonzero sum, no change
        send_instr(OP_QUOFIX, '1);               // same signs, no change
        send_instr(OP_INIT_U, '1);
        send_instr(OP_REMFIX, '0);               // positive dividend ignores fix
        send_instr(OP_STEP, 32'h7FFF_FFFF);
        send_instr(OP_STEP, 32'h0000_0001);
        send_instr(OP_LOAD, '0);
        send_instr(OP_STEP, '0);

        // Random: mostly complete divisions, some cut short, some noise.
        while (instrs_sent < RandomInstrs) begin
            if (instrs_sent >= RandomInstrs - QuietTail)
                idle_on = 1'b0;
            else
                idle_on = ($urandom_range(0, 3) != 0);
            if (!hold_asked && instrs_sent >= HoldAtInstr)
                hold_asked = 1'b1;
            dvs = pick_word();
            if (dvs == '0 && $urandom_range(0, 2) != 0)
                dvs = word_t'($urandom) | 32'h1;
            sgn = $urandom_range(0, 1);
            // a share of exact multiples drives the remainder fix-up's taken path
            if ($urandom_range(0, 3) == 0) begin
                dvd = dvs * word_t'($urandom_range(0, 40));
                if (sgn && $urandom_range(0, 1))
                    dvd = '0 - dvd;
            end else begin
                dvd = pick_word();
            end
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                run_division(dvd, dvs, sgn, 32, sgn || $urandom_range(0, 3) == 0);
                full_divs++;
                if (sgn)
                    signed_divs++;
            end else if (pick < 8) begin
                run_division(dvd, dvs, sgn, $urandom_range(0, 31), $urandom_range(0, 1));
                odd_runs++;
            end else begin
                repeat ($urandom_range(1, 6))
                    send_instr(op_t'($urandom_range(0, 7)), pick_word());
                odd_runs++;
            end
        end

        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);

        $display("Covered %0d instructions: %0d complete divisions (%0d signed),",
                 instrs_sent, full_divs, signed_divs);
        $display("%0d broken/noise runs, %0d zero-divisor traps, one %0d-cycle receiver hold-off.",
                 odd_runs, tracker.traps_seen, HoldCycles);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches, %0d results missing", tracker.mismatches,
                     tracker.pending());
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
